[design/wvpf_pkg.sv]
// shared types and codes for the wheel velocity pi feedforward controller
package wvpf_pkg;

	// request kinds
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_SET   = 2'd1;
	localparam logic [1:0] KIND_RESET = 2'd2;

	// configuration register indexes
	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_KP   = 3'd0;
	localparam logic [2:0] REG_KI   = 3'd1;
	localparam logic [2:0] REG_SP   = 3'd2;
	localparam logic [2:0] REG_AFG  = 3'd3;
	localparam logic [2:0] REG_VFG  = 3'd4;
	localparam logic [2:0] REG_BSC  = 3'd5;

	localparam logic [31:0] SP_RESET = 32'd4294967;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] measured_velocity;
		logic [11:0]        battery_adc;
		logic signed [31:0] target_accel;
		logic signed [31:0] target_velocity;
	} req_t;

	typedef struct packed {
		logic signed [15:0] duty;
		logic               duty_clipped;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_MSET,
		S_MLO,
		S_MHI,
		S_MACC,
		S_MFIN,
		S_DIVSET,
		S_DIV,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		OP_P,
		OP_I,
		OP_RAMP,
		OP_FA,
		OP_FV,
		OP_BATT
	} op_t;

endpackage

[design/wheel_velocity_pi_feedforward.sv]
// wheel velocity controller: pi feedback, ramp and feedforward over one shared multiplier
// a tick request works six products, each through mset, mlo, mhi, macc and mfin,
// on the one 32x32 multiplier, then the restoring duty divider
// a set-target request gives no result, a reset request gives one; one request is worked at a time
// a new request is taken while a finished result still waits at the output register
// arst_n clears control state, controller state and registers to their reset values
module wheel_velocity_pi_feedforward import wvpf_pkg::*; #(
	parameter int ADC_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  req_t                req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output rsp_t                rsp,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int AW = (ADC_BITS < 12) ? ADC_BITS : 12;
	localparam int BW = AW + 32;

	// saturate to 48 bits signed
	function automatic logic signed [47:0] sat48(input logic signed [59:0] v);
		logic signed [59:0] hi;
		logic signed [59:0] lo;
		hi = 60'sd140737488355327;
		lo = -60'sd140737488355328;
		if (v > hi) return hi[47:0];
		else if (v < lo) return lo[47:0];
		else return v[47:0];
	endfunction

	// saturate to 32 bits signed
	function automatic logic signed [31:0] sat32(input logic signed [58:0] v);
		logic signed [58:0] hi;
		logic signed [58:0] lo;
		hi = 59'sd2147483647;
		lo = -59'sd2147483648;
		if (v > hi) return hi[31:0];
		else if (v < lo) return lo[31:0];
		else return v[31:0];
	endfunction

	state_t state_q, state_d;
	op_t    op_q;

	logic [31:0] kp_q, ki_q, sp_q, afg_q, vfg_q, bsc_q;

	logic signed [31:0] last_vel_q, ideal_q, cmd_acc_q, cmd_vel_q, start_vel_q;
	logic signed [47:0] ei_q;

	logic signed [31:0] meas_q;
	logic [AW-1:0]      adc_q;
	logic signed [32:0] diff_q;
	logic signed [31:0] accel_q, base_q;
	logic signed [57:0] p_q, i_q, fa_q;
	logic signed [47:0] corr_q;
	logic signed [58:0] volt_q;
	logic [BW-1:0]      batt_q;

	logic [47:0] mag_q;
	logic        neg_q;
	logic [63:0] prod_q;
	logic [79:0] acc_q;

	logic [BW-1:0] rem_q;
	logic [16:0]   q_q;
	logic [3:0]    cnt_q;
	logic          vneg_q;

	logic rsp_valid_q;
	rsp_t rsp_q;

	logic                cfg_wr;
	logic                accept;
	logic                rsp_load;
	logic signed [47:0]  a_sel;
	logic [31:0]         gain;
	logic [31:0]         mul_a;
	logic [79:0]         shifted;
	logic signed [57:0]  res;
	logic signed [32:0]  diff_c;
	logic                pin;
	logic signed [59:0]  corr_sum;
	logic signed [58:0]  vmag;
	logic [65:0]         vmag_sh;
	logic                far;
	logic [BW:0]         r2;
	logic                sub_ok;
	rsp_t                rsp_c;

	// apb port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[4:2])
			REG_KP:  prdata = kp_q;
			REG_KI:  prdata = ki_q;
			REG_SP:  prdata = sp_q;
			REG_AFG: prdata = afg_q;
			REG_VFG: prdata = vfg_q;
			REG_BSC: prdata = bsc_q;
			default: prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q  <= 32'd0;
			ki_q  <= 32'd0;
			sp_q  <= SP_RESET;
			afg_q <= 32'd0;
			vfg_q <= 32'd0;
			bsc_q <= 32'd0;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_KP:  kp_q  <= pwdata;
				REG_KI:  ki_q  <= pwdata;
				REG_SP:  sp_q  <= pwdata;
				REG_AFG: afg_q <= pwdata;
				REG_VFG: vfg_q <= pwdata;
				REG_BSC: bsc_q <= pwdata;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (req.kind == KIND_TICK) state_d = S_PREP;
					else if (req.kind == KIND_RESET) state_d = S_DONE;
				end
			end
			S_PREP:   state_d = S_MSET;
			S_MSET:   state_d = S_MLO;
			S_MLO:    state_d = S_MHI;
			S_MHI:    state_d = S_MACC;
			S_MACC:   state_d = S_MFIN;
			S_MFIN:   state_d = (op_q == OP_BATT) ? S_DIVSET : S_MSET;
			S_DIVSET: state_d = (batt_q == '0 || far) ? S_DONE : S_DIV;
			S_DIV:    state_d = (cnt_q == 4'd15) ? S_DONE : S_DIV;
			S_DONE:   state_d = (!rsp_valid_q || !rsp_stall) ? S_IDLE : S_DONE;
			default:  state_d = S_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		req_stall = (state_q != S_IDLE);
		rsp_load  = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);
	end

	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// operand and gain selection for the shared multiplier
	always_comb begin
		case (op_q)
			OP_P:    begin a_sel = 48'(diff_q);  gain = kp_q;  end
			OP_I:    begin a_sel = ei_q;          gain = ki_q;  end
			OP_RAMP: begin a_sel = 48'(accel_q); gain = sp_q;  end
			OP_FA:   begin a_sel = 48'(accel_q); gain = afg_q; end
			OP_FV:   begin a_sel = corr_q;        gain = vfg_q; end
			OP_BATT: begin a_sel = $signed({{(48-AW){1'b0}}, adc_q}); gain = bsc_q; end
			default: begin a_sel = '0;            gain = '0;    end
		endcase
		mul_a = (state_q == S_MHI) ? {16'd0, mag_q[47:32]} : mag_q[31:0];
	end

	// product shift and sign
	always_comb begin
		case (op_q)
			OP_RAMP: shifted = acc_q >> 32;
			OP_BATT: shifted = acc_q;
			default: shifted = acc_q >> 24;
		endcase
		res = neg_q ? -$signed({1'b0, shifted[56:0]}) : $signed({1'b0, shifted[56:0]});
	end

	// tick preparation terms
	always_comb begin
		diff_c = 33'(ideal_q) - 33'(meas_q);
		if (cmd_vel_q >= start_vel_q) pin = (cmd_vel_q <= meas_q);
		else pin = (cmd_vel_q >= meas_q);
		corr_sum = 60'(ideal_q) + 60'(p_q) + 60'(i_q);
	end

	// divider terms
	always_comb begin
		vmag    = volt_q[58] ? -volt_q : volt_q;
		vmag_sh = {vmag[58:0], 7'd0};
		far     = (vmag_sh >= 66'(batt_q));
		r2      = {rem_q, 1'b0};
		sub_ok  = (r2 >= {1'b0, batt_q});
	end

	// result formatting
	always_comb begin
		if (vneg_q) begin
			if (q_q > 17'd32768) begin
				rsp_c.duty = 16'sh8000;
				rsp_c.duty_clipped = 1'b1;
			end else begin
				rsp_c.duty = 16'(-$signed({1'b0, q_q}));
				rsp_c.duty_clipped = 1'b0;
			end
		end else begin
			if (q_q > 17'd32767) begin
				rsp_c.duty = 16'sh7FFF;
				rsp_c.duty_clipped = 1'b1;
			end else begin
				rsp_c.duty = $signed(q_q[15:0]);
				rsp_c.duty_clipped = 1'b0;
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_P;
			cnt_q       <= 4'd0;
			rsp_valid_q <= 1'b0;
			last_vel_q  <= '0;
			ideal_q     <= '0;
			ei_q        <= '0;
			cmd_acc_q   <= '0;
			cmd_vel_q   <= '0;
			start_vel_q <= '0;
		end else begin
			state_q <= state_d;
			if (rsp_load) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && req.kind == KIND_SET) begin
						cmd_acc_q   <= req.target_accel;
						cmd_vel_q   <= req.target_velocity;
						start_vel_q <= last_vel_q;
					end else if (accept && req.kind == KIND_RESET) begin
						last_vel_q  <= '0;
						ideal_q     <= '0;
						ei_q        <= '0;
						cmd_acc_q   <= '0;
						cmd_vel_q   <= '0;
						start_vel_q <= '0;
					end
				end
				S_PREP: begin
					last_vel_q <= meas_q;
					ei_q       <= sat48(60'(ei_q) + 60'(diff_c));
					op_q       <= OP_P;
				end
				S_MFIN: begin
					if (op_q == OP_RAMP) ideal_q <= sat32(59'(base_q) + 59'(res));
					case (op_q)
						OP_P:    op_q <= OP_I;
						OP_I:    op_q <= OP_RAMP;
						OP_RAMP: op_q <= OP_FA;
						OP_FA:   op_q <= OP_FV;
						OP_FV:   op_q <= OP_BATT;
						default: op_q <= OP_P;
					endcase
				end
				S_DIVSET: cnt_q <= 4'd0;
				S_DIV:    cnt_q <= cnt_q + 4'd1;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (rsp_load) rsp_q <= rsp_c;
		case (state_q)
			S_IDLE: begin
				meas_q <= req.measured_velocity;
				adc_q  <= req.battery_adc[AW-1:0];
				q_q    <= 17'd0;
				vneg_q <= 1'b0;
			end
			S_PREP: begin
				diff_q  <= diff_c;
				accel_q <= pin ? 32'sd0 : cmd_acc_q;
				base_q  <= pin ? cmd_vel_q : ideal_q;
			end
			S_MSET: begin
				mag_q <= a_sel[47] ? 48'(-a_sel) : a_sel;
				neg_q <= a_sel[47];
			end
			S_MLO: prod_q <= mul_a * gain;
			S_MHI: begin
				acc_q  <= {16'd0, prod_q};
				prod_q <= mul_a * gain;
			end
			S_MACC: acc_q <= acc_q + {prod_q[47:0], 32'd0};
			S_MFIN: begin
				case (op_q)
					OP_P:    p_q    <= res;
					OP_I:    i_q    <= res;
					OP_FA: begin
						fa_q   <= res;
						corr_q <= sat48(corr_sum);
					end
					OP_FV:   volt_q <= 59'(fa_q) + 59'(res);
					OP_BATT: batt_q <= shifted[BW-1:0];
					default: ;
				endcase
			end
			S_DIVSET: begin
				q_q    <= (batt_q != '0 && far) ? 17'h10000 : 17'd0;
				vneg_q <= (batt_q != '0) && volt_q[58];
				rem_q  <= vmag_sh[BW-1:0];
			end
			S_DIV: begin
				rem_q <= sub_ok ? BW'(r2 - {1'b0, batt_q}) : r2[BW-1:0];
				q_q   <= {q_q[15:0], sub_ok};
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	// an accepted tick starts the sequence
	a_tick_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.kind == KIND_TICK |=> state_q == S_PREP)
		else $error("tick did not start the sequence");

	// a result appears only out of the hand-off state
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result raised outside hand-off");

	// the quotient stays inside sixteen bits while dividing
	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> !q_q[16])
		else $error("duty quotient overflow");
`endif

endmodule

[verif/wvpf_checker.sv]
// checker for the wheel velocity controller: duty prediction and result comparison
`timescale 1ns / 1ps
module wvpf_checker import wvpf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_stall,
	input  req_t              req,
	input  logic              rsp_valid,
	input  logic              rsp_stall,
	input  rsp_t              rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output int                pending,
	output int                failures,
	output int                duties_seen,
	output int                clipped_seen
);

	localparam longint S48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint S48_MIN = -64'sh0000_8000_0000_0000;
	localparam longint S32_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam longint S32_MIN = -64'sh0000_0000_8000_0000;

	// register copies, followed from the configuration bus
	logic [31:0] kp, ki, period, accel_gain, vel_gain, batt_scale;

	// controller state copies
	longint last_vel, ideal_vel, integ, cmd_accel, cmd_vel, start_vel;

	rsp_t duty_expect[$];

	initial begin
		failures = 0;
		duties_seen = 0;
		clipped_seen = 0;
		pending = 0;
	end

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// magnitude product by an unsigned gain, shifted, truncated toward zero
	function automatic longint gain_mul(longint a, logic [31:0] g, int s);
		logic [63:0] mag;
		logic [95:0] prod;
		longint res;
		mag = a < 0 ? -a : a;
		prod = {32'b0, mag} * {64'b0, g};
		res = longint'(prod >> s);
		return a < 0 ? -res : res;
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		failures++;
	endtask

	// one request through the controller; returns 1 when a duty result follows
	function automatic bit predict_duty(req_t r, output rsp_t d);
		longint meas, diff, p, i, acc, corr, volt, duty;
		logic [63:0] batt, vmag, q;
		d = '0;
		if (r.kind == KIND_SET) begin
			cmd_accel = longint'(r.target_accel);
			cmd_vel = longint'(r.target_velocity);
			start_vel = last_vel;
			return 0;
		end
		if (r.kind == KIND_RESET) begin
			last_vel = 0; ideal_vel = 0; integ = 0;
			cmd_accel = 0; cmd_vel = 0; start_vel = 0;
			return 1;
		end
		if (r.kind != KIND_TICK)
			return 0;

		// pi on the ideal velocity from before the ramp
		meas = longint'(r.measured_velocity);
		last_vel = meas;
		diff = ideal_vel - meas;
		integ = clamp(integ + diff, S48_MIN, S48_MAX);
		p = gain_mul(diff, kp, 24);
		i = gain_mul(integ, ki, 24);

		// ramp, pinned to the target once the measurement gets there
		acc = cmd_accel;
		if (cmd_vel >= start_vel) begin
			if (cmd_vel <= meas) begin
				acc = 0;
				ideal_vel = cmd_vel;
			end
		end else if (cmd_vel >= meas) begin
			acc = 0;
			ideal_vel = cmd_vel;
		end
		ideal_vel = clamp(ideal_vel + gain_mul(acc, period, 32), S32_MIN, S32_MAX);

		// feedforward voltage and duty
		corr = clamp(ideal_vel + p + i, S48_MIN, S48_MAX);
		volt = gain_mul(acc, accel_gain, 24) + gain_mul(corr, vel_gain, 24);
		batt = {52'b0, r.battery_adc} * {32'b0, batt_scale};
		if (batt == 0)
			return 1;
		vmag = volt < 0 ? -volt : volt;
		if ((vmag << 8) >= 2 * batt)
			q = 64'd65536;
		else
			q = (vmag << 23) / batt;
		if (volt < 0) begin
			if (q > 32768) begin
				duty = -32768;
				d.duty_clipped = 1'b1;
			end else
				duty = -longint'(q);
		end else begin
			if (q > 32767) begin
				duty = 32767;
				d.duty_clipped = 1'b1;
			end else
				duty = longint'(q);
		end
		d.duty = duty[15:0];
		return 1;
	endfunction

	// register writes and accepted requests and results
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			kp = 0; ki = 0; period = SP_RESET;
			accel_gain = 0; vel_gain = 0; batt_scale = 0;
			last_vel = 0; ideal_vel = 0; integ = 0;
			cmd_accel = 0; cmd_vel = 0; start_vel = 0;
			duty_expect.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_KP:  kp = pwdata;
					REG_KI:  ki = pwdata;
					REG_SP:  period = pwdata;
					REG_AFG: accel_gain = pwdata;
					REG_VFG: vel_gain = pwdata;
					REG_BSC: batt_scale = pwdata;
					default: ;
				endcase
			end
			if (rsp_valid && !rsp_stall) begin
				if (duty_expect.size() == 0) begin
					$display("mismatch at %0t: duty result with none expected", $realtime);
					failures++;
				end else begin
					want = duty_expect.pop_front();
					duties_seen++;
					if (want.duty_clipped)
						clipped_seen++;
					if (rsp.duty !== want.duty)
						report("duty", int'(rsp.duty), int'(want.duty));
					if (rsp.duty_clipped !== want.duty_clipped)
						report("duty_clipped", rsp.duty_clipped, want.duty_clipped);
				end
			end
			if (req_valid && !req_stall) begin
				if (predict_duty(req, want))
					duty_expect.push_back(want);
			end
		end
		pending = duty_expect.size();
	end

endmodule

[verif/wheel_velocity_pi_feedforward_test.sv]
// testbench top for the wheel velocity controller: stimulus, stalls and verdict
`timescale 1ns / 1ps
module wheel_velocity_pi_feedforward_test import wvpf_pkg::*;;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int SETTLE = 64;
	localparam int RANDOM_ITEMS = 1880;
	localparam int VEL_1000 = 1000 * 65536;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	int pending, failures, duties_seen, clipped_seen;
	int settings_run = 0;
	int stall_left = 0;
	logic [31:0] stall_clock = '0;
	int stall_roll;

	wheel_velocity_pi_feedforward dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	wvpf_checker chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.pending(pending), .failures(failures),
		.duties_seen(duties_seen), .clipped_seen(clipped_seen)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// result stalls: short bursts, a few long ones, and quiet stretches
	always @(negedge clk) begin
		stall_clock <= stall_clock + 1;
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_stall <= 1'b1;
		end else if (stall_clock[9]) begin
			rsp_stall <= 1'b0;
		end else begin
			stall_roll = $urandom_range(99);
			if (stall_roll < 20) begin
				rsp_stall <= 1'b1;
				stall_left <= stall_roll < 2 ? $urandom_range(20, 80) : $urandom_range(0, 3);
			end else
				rsp_stall <= 1'b0;
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_W'(idx) << 2;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// stop sending, drain every expected duty, then let the controller settle
	task automatic wait_idle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_gains(logic [31:0] kp, ki, sp, afg, vfg, bsc);
		wait_idle();
		reg_write(REG_KP, kp);
		reg_write(REG_KI, ki);
		reg_write(REG_SP, sp);
		reg_write(REG_AFG, afg);
		reg_write(REG_VFG, vfg);
		reg_write(REG_BSC, bsc);
		settings_run++;
	endtask

	task automatic send(req_t r, int gap);
		@(negedge clk);
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		if (gap > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (roll < 65)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(20, 60);
	endfunction

	function automatic req_t make_req(logic [1:0] kind, int vel, int adc);
		req_t r;
		r.kind = kind;
		r.measured_velocity = vel;
		r.battery_adc = adc[11:0];
		r.target_accel = $urandom;
		r.target_velocity = $urandom;
		return r;
	endfunction

	function automatic int small_vel();
		return int'($urandom_range(2 * VEL_1000)) - VEL_1000;
	endfunction

	// mostly plausible ticks after a target, with noise and full-range values
	function automatic req_t random_req();
		req_t r;
		int roll;
		roll = $urandom_range(99);
		r = make_req(KIND_TICK, $urandom_range(99) < 85 ? small_vel() : int'($urandom),
			$urandom_range(99) < 85 ? $urandom_range(2500, 4095) : $urandom_range(4095));
		if ($urandom_range(99) < 3)
			r.battery_adc = '0;
		if (roll >= 80 && roll < 93) begin
			r.kind = KIND_SET;
			if ($urandom_range(99) < 80) begin
				r.target_accel = int'($urandom_range(2 * 5000 * 65536)) - 5000 * 65536;
				r.target_velocity = small_vel();
			end
		end else if (roll >= 93 && roll < 97)
			r.kind = KIND_RESET;
		else if (roll >= 97)
			r.kind = KIND_UNUSED;
		return r;
	endfunction

	task automatic random_phase(int count);
		for (int n = 0; n < count; n++)
			send(random_req(), pick_gap());
	endtask

	initial begin
		#20_000_000;
		$display("timeout with %0d duty results still expected", pending);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		req_t r;
		int per_phase;
		per_phase = RANDOM_ITEMS / 6;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset register values: no battery scale, so every tick gives zero duty
		send(make_req(KIND_TICK, VEL_1000, 4095), 0);
		send(make_req(KIND_RESET, 0, 0), 1);

		// directed: realistic gains, ramps both ways, extremes and odd kinds
		set_gains(32'h0080_0000, 32'h0010_0000, SP_RESET, 32'd5000, 32'd83886, 32'd50331);
		r = make_req(KIND_SET, 0, 0);
		r.target_accel = 2000 * 65536;
		r.target_velocity = 500 * 65536;
		send(r, 0);
		send(make_req(KIND_TICK, 0, 3000), 0);
		send(make_req(KIND_TICK, 100 * 65536, 4095), 0);
		send(make_req(KIND_TICK, 600 * 65536, 3000), 2);
		send(make_req(KIND_TICK, 32'sh7FFF_FFFF, 4095), 0);
		send(make_req(KIND_TICK, 32'sh8000_0000, 4095), 0);
		send(make_req(KIND_TICK, 0, 0), 0);
		send(make_req(KIND_TICK, 0, 1), 0);
		r = make_req(KIND_SET, 0, 0);
		r.target_accel = -3000 * 65536;
		r.target_velocity = -400 * 65536;
		send(r, 0);
		send(make_req(KIND_TICK, -100 * 65536, 2000), 0);
		send(make_req(KIND_TICK, -500 * 65536, 2000), 0);
		r = make_req(KIND_SET, 0, 0);
		r.target_accel = 32'sh8000_0000;
		r.target_velocity = 32'sh7FFF_FFFF;
		send(r, 0);
		send(make_req(KIND_TICK, -VEL_1000, 1), 0);
		send(make_req(KIND_UNUSED, 0, 4095), 0);
		send(make_req(KIND_RESET, -1, 4095), 0);
		send(make_req(KIND_TICK, 0, 4095), 0);

		// saturating everything: integrator and duty clip
		set_gains('1, '1, '1, '1, '1, '1);
		for (int n = 0; n < 6; n++)
			send(make_req(KIND_TICK, n[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000, 4095), 0);

		// random phases over several register settings
		set_gains(32'h0080_0000, 32'h0010_0000, SP_RESET, 32'd5000, 32'd83886, 32'd50331);
		random_phase(per_phase / 2);
		wait_idle();
		random_phase(per_phase - per_phase / 2);
		set_gains('1, '1, '1, '1, '1, '1);
		random_phase(per_phase);
		set_gains('0, '0, '0, '0, '0, 32'd1);
		random_phase(per_phase);
		set_gains(32'h0200_0000, 32'h0000_4000, 32'h0100_0000, 32'd200_000, 32'd20_000,
			32'd3000);
		random_phase(per_phase);
		for (int n = 0; n < 2; n++) begin
			set_gains($urandom >> $urandom_range(31), $urandom >> $urandom_range(31),
				$urandom, $urandom >> $urandom_range(31), $urandom >> $urandom_range(31),
				$urandom >> $urandom_range(31));
			random_phase(per_phase);
		end

		@(negedge clk);
		req_valid <= 1'b0;
		wait_idle();
		repeat (100) @(posedge clk);
		$display("covered %0d register settings, tick/set/reset requests with stalls",
			settings_run);
		$display("checked %0d duty results, %0d of them clipped", duties_seen, clipped_seen);
		if (failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[sim.f]
design/wvpf_pkg.sv
design/wheel_velocity_pi_feedforward.sv
verif/wvpf_checker.sv
verif/wheel_velocity_pi_feedforward_test.sv
